// ----- design/frame_speed_safety_monitor_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the frame speed safety monitor
// ---------------------------------------------------------------------------
`ifndef FRAME_SPEED_SAFETY_MONITOR_TOP_DEFINES_SVH
`define FRAME_SPEED_SAFETY_MONITOR_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fssm_pkg.sv -----
// ---------------------------------------------------------------------------
// fssm_pkg
// Shared widths, types and codes of the frame speed safety monitor.
// ---------------------------------------------------------------------------
package fssm_pkg;
	localparam int DEF_NUM_FRAMES = 8;
	localparam int POS_W = 32;
	localparam int TIME_W = 48;
	localparam int SPEED_W = 32;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DIFF_W = 33;
	localparam int SUMSQ_W = 68;
	localparam int ROOT_W = 34;
	localparam int PROD_W = 44;
	localparam int QUO_W = 44;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_LIMIT = 2'd0,
		REG_STALE_LIMIT = 2'd1,
		REG_ALLOWED_MISSED = 2'd2,
		REG_MIN_INTERVAL = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SQUARE,
		ST_ROOT,
		ST_MULK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {U_IDLE, U_SQ, U_RT, U_MK, U_DV, U_FIN} ustate_t;
endpackage

// ----- design/fssm_if.sv -----
// ---------------------------------------------------------------------------
// Stream and configuration interfaces
// Valid/ready channels of the monitor.
// ---------------------------------------------------------------------------
interface fssm_in_if;
	logic valid;
	logic ready;
	logic [2:0] frame_index;
	logic signed [31:0] pos_x_um;
	logic signed [31:0] pos_y_um;
	logic signed [31:0] pos_z_um;
	logic [47:0] sample_time_us;
	logic [47:0] now_time_us;
	modport source (output valid, frame_index, pos_x_um, pos_y_um, pos_z_um,
		sample_time_us, now_time_us, input ready);
	modport sink (input valid, frame_index, pos_x_um, pos_y_um, pos_z_um,
		sample_time_us, now_time_us, output ready);
endinterface

interface fssm_out_if;
	logic valid;
	logic ready;
	logic [2:0] frame_index_out;
	logic [31:0] speed_mm_s;
	logic speed_valid;
	logic stale;
	logic stop_request;
	logic [7:0] missed_count_out;
	modport source (output valid, frame_index_out, speed_mm_s, speed_valid, stale,
		stop_request, missed_count_out, input ready);
	modport sink (input valid, frame_index_out, speed_mm_s, speed_valid, stale,
		stop_request, missed_count_out, output ready);
endinterface

interface fssm_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/frame_speed_safety_monitor_top.sv -----
// ---------------------------------------------------------------------------
// frame_speed_safety_monitor_top
// Per-frame staleness count and speed check of timestamped position samples.
// ---------------------------------------------------------------------------
// channel | dir | payload
// smp     | in  | frame_index, pos_x/y/z_um, sample_time_us, now_time_us
// res     | out | frame_index_out, speed_mm_s, speed_valid, stale, stop_request,
//         |     | missed_count_out
// cfg     | in  | index, data
// One sample at a time. A computed speed passes through lookup, 99 square
// steps, 34 root steps, one x1000 step, 44 divide steps and finish before
// its result. Other samples skip the speed unit. The next sample is taken
// only after the result has been taken.
// Reset clears config to defaults, primed bits and miss counters.
// A stalled result holds; the next sample waits until it is taken.
module frame_speed_safety_monitor_top #(
	parameter int NUM_FRAMES = fssm_pkg::DEF_NUM_FRAMES
) (
	input logic clk,
	input logic arst_n,
	fssm_in_if.sink smp,
	fssm_out_if.source res,
	fssm_cfg_if.sink cfg
);
	import fssm_pkg::*;
	`include "frame_speed_safety_monitor_top_defines.svh"

	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	state_t st_q, st_d;
	logic [31:0] speed_limit_q;
	logic [23:0] stale_limit_q;
	logic [7:0] allowed_missed_q;
	logic [15:0] min_interval_q;
	logic [NUM_FRAMES-1:0] primed_q;
	logic [CNT_W-1:0] missed_q [NUM_FRAMES];

	logic [POS_W-1:0] mem_x [NUM_FRAMES];
	logic [POS_W-1:0] mem_y [NUM_FRAMES];
	logic [POS_W-1:0] mem_z [NUM_FRAMES];
	logic [TIME_W-1:0] mem_t [NUM_FRAMES];
	logic [POS_W-1:0] rd_x_q, rd_y_q, rd_z_q;
	logic [TIME_W-1:0] rd_t_q;

	logic [2:0] fidx_q;
	logic in_range_q;
	logic [POS_W-1:0] x_q, y_q, z_q;
	logic [TIME_W-1:0] ts_q, now_q;

	logic [2:0] o_frame_q;
	logic [SPEED_W-1:0] o_speed_q;
	logic o_valid_q, o_sv_q, o_stale_q, o_stop_q;
	logic [CNT_W-1:0] o_cnt_q;

	logic acc_in, acc_out, wr_pose, upd_cnt;
	logic [CNT_W-1:0] cnt_new;
	logic [FW-1:0] fsel;
	logic u_start, u_busy, u_done;
	logic [SPEED_W-1:0] u_speed;
	logic [TIME_W-1:0] age, dtv;
	logic [DIFF_W-1:0] ax, ay, az;
	logic [CNT_W-1:0] cur_cnt, inc_cnt;
	logic is_primed, is_stale, do_speed;

	assign smp.ready = (st_q == ST_IDLE) && !o_valid_q;
	assign acc_in = smp.valid && smp.ready;
	assign acc_out = res.valid && res.ready;
	assign cfg.ready = 1'b1;
	assign fsel = FW'(fidx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= 32'd250;
			stale_limit_q <= 24'd20000;
			allowed_missed_q <= 8'd3;
			min_interval_q <= 16'd1;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_SPEED_LIMIT: speed_limit_q <= cfg.data;
				REG_STALE_LIMIT: stale_limit_q <= cfg.data[23:0];
				REG_ALLOWED_MISSED: allowed_missed_q <= cfg.data[7:0];
				REG_MIN_INTERVAL: min_interval_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			fidx_q <= smp.frame_index;
			in_range_q <= (32'(smp.frame_index) < NUM_FRAMES);
			x_q <= smp.pos_x_um;
			y_q <= smp.pos_y_um;
			z_q <= smp.pos_z_um;
			ts_q <= smp.sample_time_us;
			now_q <= smp.now_time_us;
		end
		if (st_q == ST_LOOK) begin
			rd_x_q <= mem_x[fsel];
			rd_y_q <= mem_y[fsel];
			rd_z_q <= mem_z[fsel];
			rd_t_q <= mem_t[fsel];
		end
		if (wr_pose) begin
			mem_x[fsel] <= x_q;
			mem_y[fsel] <= y_q;
			mem_z[fsel] <= z_q;
			mem_t[fsel] <= ts_q;
		end
	end

	function automatic logic [DIFF_W-1:0] absd(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'($signed(a)) - DIFF_W'($signed(b));
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

	assign is_primed = in_range_q && primed_q[fsel];
	assign cur_cnt = missed_q[fsel];
	assign age = (now_q > ts_q) ? now_q - ts_q : ts_q - now_q;
	assign is_stale = age > TIME_W'(stale_limit_q);
	assign dtv = ts_q - rd_t_q;
	assign do_speed = (ts_q > rd_t_q) && (dtv > TIME_W'(min_interval_q));
	assign ax = absd(x_q, rd_x_q);
	assign ay = absd(y_q, rd_y_q);
	assign az = absd(z_q, rd_z_q);
	assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 8'd1;

	fssm_speed_unit u_speed_unit (
		.clk(clk), .arst_n(arst_n), .start(u_start),
		.ax(ax), .ay(ay), .az(az), .dt(dtv),
		.busy(u_busy), .done(u_done), .speed(u_speed)
	);

	always_comb begin
		st_d = st_q;
		u_start = 1'b0;
		wr_pose = 1'b0;
		upd_cnt = 1'b0;
		cnt_new = cur_cnt;
		unique case (st_q)
			ST_IDLE: if (acc_in) st_d = ST_LOOK;
			ST_LOOK: st_d = ST_SQUARE;
			ST_SQUARE: begin
				if (!in_range_q) begin
					st_d = ST_DONE;
				end else if (!primed_q[fsel]) begin
					wr_pose = 1'b1;
					upd_cnt = 1'b1;
					cnt_new = '0;
					st_d = ST_DONE;
				end else if (is_stale) begin
					upd_cnt = 1'b1;
					cnt_new = (inc_cnt > allowed_missed_q) ? '0 : inc_cnt;
					st_d = ST_DONE;
				end else if (do_speed) begin
					u_start = 1'b1;
					st_d = ST_ROOT;
				end else begin
					wr_pose = 1'b1;
					st_d = ST_DONE;
				end
			end
			ST_ROOT: if (u_done) begin
				wr_pose = 1'b1;
				st_d = ST_DONE;
			end
			ST_MULK: st_d = ST_IDLE;
			ST_DIV: st_d = ST_IDLE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			primed_q <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) missed_q[i] <= '0;
			o_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_SQUARE && in_range_q && !primed_q[fsel])
				primed_q[fsel] <= 1'b1;
			if (upd_cnt)
				missed_q[fsel] <= cnt_new;
			if (st_d == ST_DONE)
				o_valid_q <= 1'b1;
			else if (acc_out)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_SQUARE) begin
			o_frame_q <= fidx_q;
			o_speed_q <= '0;
			o_sv_q <= is_primed && !is_stale;
			o_stale_q <= is_primed && is_stale;
			o_stop_q <= is_primed && is_stale && (inc_cnt > allowed_missed_q);
			o_cnt_q <= !is_primed ? '0 : (is_stale ? cnt_new : cur_cnt);
		end
		if (st_q == ST_ROOT && u_done) begin
			o_speed_q <= u_speed;
			o_stop_q <= u_speed > speed_limit_q;
		end
	end

	assign res.valid = o_valid_q;
	assign res.frame_index_out = o_frame_q;
	assign res.speed_mm_s = o_speed_q;
	assign res.speed_valid = o_sv_q;
	assign res.stale = o_stale_q;
	assign res.stop_request = o_stop_q;
	assign res.missed_count_out = o_cnt_q;

	`FSM_ASSERT_IMP(a_no_accept_busy, clk, arst_n, st_q != ST_IDLE, !smp.ready,
		"sample accepted while busy")
	`FSM_ASSERT_IMP(a_unit_only_root, clk, arst_n, u_done, st_q == ST_ROOT,
		"speed unit finished outside wait")
	`FSM_ASSERT_IMP(a_unit_busy_root, clk, arst_n, u_busy, st_q == ST_ROOT,
		"speed unit running outside wait")
	`FSM_ASSERT_NXT(a_res_hold, clk, arst_n, res.valid && !res.ready, res.valid,
		"result dropped while stalled")
	`FSM_ASSERT_IMP(a_flags_excl, clk, arst_n, res.valid,
		!(res.speed_valid && res.stale), "fresh and stale together")
endmodule

// ----- design/fssm_speed_unit.sv -----
// ---------------------------------------------------------------------------
// fssm_speed_unit
// Bit-serial speed: sum of squares by shift-add, restoring square root two bits
// per step, times 1000 by shift-subtract, restoring divide one bit per cycle.
// ---------------------------------------------------------------------------
module fssm_speed_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [fssm_pkg::DIFF_W-1:0] ax,
	input  logic [fssm_pkg::DIFF_W-1:0] ay,
	input  logic [fssm_pkg::DIFF_W-1:0] az,
	input  logic [fssm_pkg::TIME_W-1:0] dt,
	output logic busy,
	output logic done,
	output logic [fssm_pkg::SPEED_W-1:0] speed
);
	import fssm_pkg::*;

	ustate_t st_q, st_d;
	logic [6:0] cnt_q, cnt_d;
	logic [1:0] axis_q, axis_d;
	logic [SUMSQ_W-1:0] mcand_q, mcand_d;
	logic [DIFF_W-1:0] mplier_q, mplier_d;
	logic [SUMSQ_W-1:0] acc_q, acc_d;
	logic [SUMSQ_W-1:0] rad_q, rad_d;
	logic [ROOT_W+1:0] rem_q, rem_d;
	logic [ROOT_W-1:0] root_q, root_d;
	logic [PROD_W-1:0] num_q, num_d;
	logic [TIME_W:0] drem_q, drem_d;
	logic [TIME_W-1:0] dt_q, dt_d;
	logic [ROOT_W+1:0] trial;
	logic [TIME_W:0] dtrial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= U_IDLE;
			cnt_q <= '0;
			axis_q <= '0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			axis_q <= axis_d;
		end
	end

	always_ff @(posedge clk) begin
		mcand_q <= mcand_d;
		mplier_q <= mplier_d;
		acc_q <= acc_d;
		rad_q <= rad_d;
		rem_q <= rem_d;
		root_q <= root_d;
		num_q <= num_d;
		drem_q <= drem_d;
		dt_q <= dt_d;
	end

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		axis_d = axis_q;
		mcand_d = mcand_q;
		mplier_d = mplier_q;
		acc_d = acc_q;
		rad_d = rad_q;
		rem_d = rem_q;
		root_d = root_q;
		num_d = num_q;
		drem_d = drem_q;
		dt_d = dt_q;
		trial = {rem_q[ROOT_W-1:0], rad_q[SUMSQ_W-1 -: 2]} - {root_q, 2'b01};
		dtrial = {drem_q[TIME_W-1:0], num_q[PROD_W-1]} - {1'b0, dt_q};
		unique case (st_q)
			U_IDLE: begin
				if (start) begin
					st_d = U_SQ;
					cnt_d = '0;
					axis_d = '0;
					mcand_d = SUMSQ_W'(ax);
					mplier_d = ax;
					acc_d = '0;
					dt_d = dt;
				end
			end
			U_SQ: begin
				if (mplier_q[0])
					acc_d = acc_q + mcand_q;
				mcand_d = mcand_q << 1;
				mplier_d = mplier_q >> 1;
				cnt_d = cnt_q + 7'd1;
				if (cnt_q == 7'(DIFF_W - 1)) begin
					cnt_d = '0;
					axis_d = axis_q + 2'd1;
					if (axis_q == 2'd0) begin
						mcand_d = SUMSQ_W'(ay);
						mplier_d = ay;
					end else if (axis_q == 2'd1) begin
						mcand_d = SUMSQ_W'(az);
						mplier_d = az;
					end else begin
						st_d = U_RT;
						rad_d = acc_d;
						rem_d = '0;
						root_d = '0;
					end
				end
			end
			U_RT: begin
				if (!trial[ROOT_W+1]) begin
					rem_d = trial;
					root_d = {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_d = {rem_q[ROOT_W-1:0], rad_q[SUMSQ_W-1 -: 2]};
					root_d = {root_q[ROOT_W-2:0], 1'b0};
				end
				rad_d = rad_q << 2;
				cnt_d = cnt_q + 7'd1;
				if (cnt_q == 7'(ROOT_W - 1)) begin
					st_d = U_MK;
					cnt_d = '0;
				end
			end
			U_MK: begin
				// d*1000 = (d<<10) - (d<<4) - (d<<3)
				num_d = (PROD_W'(root_q) << 10) - (PROD_W'(root_q) << 4)
					- (PROD_W'(root_q) << 3);
				drem_d = '0;
				st_d = U_DV;
			end
			U_DV: begin
				if (!dtrial[TIME_W]) begin
					drem_d = dtrial;
					num_d = {num_q[PROD_W-2:0], 1'b1};
				end else begin
					drem_d = {drem_q[TIME_W-1:0], num_q[PROD_W-1]};
					num_d = {num_q[PROD_W-2:0], 1'b0};
				end
				cnt_d = cnt_q + 7'd1;
				if (cnt_q == 7'(PROD_W - 1))
					st_d = U_FIN;
			end
			U_FIN: st_d = U_IDLE;
			default: st_d = U_IDLE;
		endcase
	end

	assign busy = (st_q != U_IDLE);
	assign done = (st_q == U_FIN);
	assign speed = (|num_q[PROD_W-1:SPEED_W]) ? '1 : num_q[SPEED_W-1:0];
endmodule
